// ===== rtl/core/epoch_seconds_to_calendar_unit_macros.svh =====
// assertion macros for the calendar conversion rtl
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define ES2C_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define ES2C_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/es2c_pkg.sv =====
// shared constants, tables and types for the calendar conversion pipeline
`timescale 1ns / 1ps

package es2c_pkg;

    // pipeline depth, one register stage per entry
    localparam int NUM_STAGES = 11;

    // calendar constants
    localparam int SEC_PER_MIN     = 60;
    localparam int HOURS_PER_DAY   = 24;
    localparam int HOURS_PER_CYCLE = 1461 * 24;
    localparam int HOURS_PER_YEAR  = 365 * 24;
    localparam int EPOCH_YEAR_OFS  = 70;
    localparam int EPOCH_WEEKDAY   = 4;
    localparam int DAYS_PER_WEEK   = 7;
    localparam int LEAP_DAY_DOY    = 60;

    // reciprocals floor(2^k / d); the estimate is at most one below the quotient
    localparam logic [26:0] R_60  = 27'((64'd1 << 32) / 64'd60);
    localparam logic [16:0] R_24  = 17'((64'd1 << 21) / 64'd24);
    localparam logic [5:0]  R_CYC = 6'((64'd1 << 21) / 64'd35064);
    localparam logic [15:0] R_7   = 16'((64'd1 << 18) / 64'd7);

    // first hour of each year inside a four-year cycle starting two years past a leap year
    localparam logic [15:0] CYCLE_YEAR_START [4] = '{
        16'd0,
        16'(HOURS_PER_YEAR),
        16'(2 * HOURS_PER_YEAR),
        16'(3 * HOURS_PER_YEAR + HOURS_PER_DAY)
    };

    // days before each month in a common year
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // handshake control shared between the sequencer and the datapath
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

endpackage

// ===== rtl/core/epoch_seconds_to_calendar_unit.sv =====
// top level: signed epoch seconds to local calendar date and time
`timescale 1ns / 1ps

// Converts a signed 32-bit count of seconds since 1970-01-01 00:00:00 UTC,
// plus the programmed zone offset, into second, minute, hour, day of month,
// month (0 = January), years since 1900 and weekday (0 = Sunday). A negative
// local time is clamped to 1970-01-01 00:00:00. Leap years follow the
// divisible-by-four rule only. The block takes one beat per cycle while
// the input is not stalled. Each beat passes in order through an input
// stage for the offset and clamp, the chain of constant divisions (seconds
// to minutes, minutes to hours, hours to days and four-year cycles,
// weekday, day of year), each done as a registered reciprocal multiply
// followed by a one-step remainder correction, and a final month lookup.
// A stalled output holds its beat while empty stages upstream keep
// filling; the input stalls only when every stage holds a beat. The user
// must write the zone offset through cfg_wr_en / zone_offset_seconds only
// while no beat is in flight; the block itself does not enforce this.

`include "epoch_seconds_to_calendar_unit_macros.svh"

module epoch_seconds_to_calendar_unit
    import es2c_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_wr_en,
    input  logic signed [16:0] zone_offset_seconds,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] epoch_seconds,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         second,
    output logic [5:0]         minute,
    output logic [4:0]         hour,
    output logic [4:0]         day_of_month,
    output logic [3:0]         month,
    output logic [7:0]         years_since_1900,
    output logic [2:0]         weekday
);

    pipe_ctrl_t ctrl;

    logic signed [16:0] zone_reg;

    // stage 0: offset and clamp
    logic [31:0] s0_raw_reg, s0_raw_next;
    logic signed [32:0] s0_sum;
    // stage 1: seconds / 60 product
    logic [58:0] s1_prod_reg, s1_prod_next;
    logic [31:0] s1_raw_reg;
    // stage 2: minute count and second
    logic [26:0] s2_mins_reg, s2_mins_next;
    logic [5:0]  s2_sec_reg, s2_sec_next;
    logic [26:0] s2_q;
    logic [31:0] s2_diff;
    logic [6:0]  s2_rem;
    // stage 3: minutes / 60 product
    logic [53:0] s3_prod_reg, s3_prod_next;
    logic [26:0] s3_mins_reg;
    logic [5:0]  s3_sec_reg;
    // stage 4: hour count and minute
    logic [20:0] s4_hours_reg, s4_hours_next;
    logic [5:0]  s4_min_reg, s4_min_next;
    logic [5:0]  s4_sec_reg;
    logic [20:0] s4_q;
    logic [26:0] s4_diff;
    logic [6:0]  s4_rem;
    // stage 5: hours / 24 and hours / cycle products
    logic [37:0] s5_dprod_reg, s5_dprod_next;
    logic [26:0] s5_cprod_reg, s5_cprod_next;
    logic [20:0] s5_hours_reg;
    logic [5:0]  s5_min_reg;
    logic [5:0]  s5_sec_reg;
    // stage 6: day count, cycle, hour within cycle, hour of day
    logic [16:0] s6_days_reg, s6_days_next;
    logic [5:0]  s6_cyc_reg, s6_cyc_next;
    logic [15:0] s6_crem_reg, s6_crem_next;
    logic [4:0]  s6_hour_reg, s6_hour_next;
    logic [5:0]  s6_min_reg;
    logic [5:0]  s6_sec_reg;
    logic [16:0] s6_dq;
    logic [20:0] s6_ddiff;
    logic [5:0]  s6_drem;
    logic [5:0]  s6_cq;
    logic [20:0] s6_cdiff;
    logic [16:0] s6_cr;
    // stage 7: year and weekday product
    logic [17:0] s7_dayp4_reg, s7_dayp4_next;
    logic [33:0] s7_wprod_reg, s7_wprod_next;
    logic [7:0]  s7_year_reg, s7_year_next;
    logic [13:0] s7_yrem_reg, s7_yrem_next;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg;
    logic [5:0]  s7_sec_reg;
    logic [1:0]  s7_yidx;
    // stage 8: weekday and day-of-year product
    logic [2:0]  s8_wday_reg, s8_wday_next;
    logic [30:0] s8_yprod_reg, s8_yprod_next;
    logic [13:0] s8_yrem_reg;
    logic [7:0]  s8_year_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg;
    logic [5:0]  s8_sec_reg;
    logic [15:0] s8_wq;
    logic [17:0] s8_wdiff;
    logic [3:0]  s8_wrem;
    // stage 9: zero-based day of year
    logic [8:0]  s9_doy0_reg, s9_doy0_next;
    logic [2:0]  s9_wday_reg;
    logic [7:0]  s9_year_reg;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_min_reg;
    logic [5:0]  s9_sec_reg;
    logic [8:0]  s9_q;
    logic [13:0] s9_diff;
    logic [5:0]  s9_rem;
    // stage 10: month lookup, output registers
    logic [4:0]  s10_mday_reg, s10_mday_next;
    logic [3:0]  s10_mon_reg, s10_mon_next;
    logic [2:0]  s10_wday_reg;
    logic [7:0]  s10_year_reg;
    logic [4:0]  s10_hour_reg;
    logic [5:0]  s10_min_reg;
    logic [5:0]  s10_sec_reg;
    logic [8:0]  s10_doy;
    logic [8:0]  s10_d;
    logic [10:0] s10_past;
    logic        s10_leap;
    // field range flags for the checks
    logic        time_ok;
    logic        date_ok;
    logic        year_ok;

    // handshake sequencing
    es2c_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    assign in_stall  = !ctrl.load[0];
    assign out_valid = ctrl.valid[NUM_STAGES-1];

    // zone offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            zone_reg <= zone_offset_seconds;
        end
    end

    // offset, clamp, and the two reciprocal products on seconds and minutes
    always_comb
    begin
        s0_sum       = 33'(epoch_seconds) + 33'(zone_reg);
        s0_raw_next  = s0_sum[32] ? 32'd0 : s0_sum[31:0];
        s1_prod_next = 59'(s0_raw_reg) * 59'(R_60);
        s3_prod_next = 54'(s2_mins_reg) * 54'(R_60);
    end

    // seconds to minutes with one correction step
    always_comb
    begin
        s2_q    = s1_prod_reg[58:32];
        s2_diff = s1_raw_reg - 32'(s2_q) * 32'(SEC_PER_MIN);
        s2_rem  = s2_diff[6:0];
        if (s2_rem >= 7'(SEC_PER_MIN))
        begin
            s2_mins_next = s2_q + 27'd1;
            s2_sec_next  = 6'(s2_rem - 7'(SEC_PER_MIN));
        end
        else
        begin
            s2_mins_next = s2_q;
            s2_sec_next  = s2_rem[5:0];
        end
    end

    // minutes to hours with one correction step, day and cycle products
    always_comb
    begin
        s4_q    = s3_prod_reg[52:32];
        s4_diff = s3_mins_reg - 27'(s4_q) * 27'(SEC_PER_MIN);
        s4_rem  = s4_diff[6:0];
        if (s4_rem >= 7'(SEC_PER_MIN))
        begin
            s4_hours_next = s4_q + 21'd1;
            s4_min_next   = 6'(s4_rem - 7'(SEC_PER_MIN));
        end
        else
        begin
            s4_hours_next = s4_q;
            s4_min_next   = s4_rem[5:0];
        end
        s5_dprod_next = 38'(s4_hours_reg) * 38'(R_24);
        s5_cprod_next = 27'(s4_hours_reg) * 27'(R_CYC);
    end

    // hours to days and to four-year cycles
    always_comb
    begin
        s6_dq    = s5_dprod_reg[37:21];
        s6_ddiff = s5_hours_reg - 21'(s6_dq) * 21'(HOURS_PER_DAY);
        s6_drem  = s6_ddiff[5:0];
        if (s6_drem >= 6'(HOURS_PER_DAY))
        begin
            s6_days_next = s6_dq + 17'd1;
            s6_hour_next = 5'(s6_drem - 6'(HOURS_PER_DAY));
        end
        else
        begin
            s6_days_next = s6_dq;
            s6_hour_next = s6_drem[4:0];
        end
        s6_cq    = s5_cprod_reg[26:21];
        s6_cdiff = s5_hours_reg - 21'(s6_cq) * 21'(HOURS_PER_CYCLE);
        s6_cr    = s6_cdiff[16:0];
        if (s6_cr >= 17'(HOURS_PER_CYCLE))
        begin
            s6_cyc_next  = s6_cq + 6'd1;
            s6_crem_next = 16'(s6_cr - 17'(HOURS_PER_CYCLE));
        end
        else
        begin
            s6_cyc_next  = s6_cq;
            s6_crem_next = s6_cr[15:0];
        end
    end

    // year within the cycle, weekday product
    always_comb
    begin
        if (s6_crem_reg < CYCLE_YEAR_START[1])
        begin
            s7_yidx = 2'd0;
        end
        else if (s6_crem_reg < CYCLE_YEAR_START[2])
        begin
            s7_yidx = 2'd1;
        end
        else if (s6_crem_reg < CYCLE_YEAR_START[3])
        begin
            s7_yidx = 2'd2;
        end
        else
        begin
            s7_yidx = 2'd3;
        end
        s7_yrem_next  = 14'(s6_crem_reg - CYCLE_YEAR_START[s7_yidx]);
        s7_year_next  = 8'({s6_cyc_reg, s7_yidx}) + 8'(EPOCH_YEAR_OFS);
        s7_dayp4_next = 18'(s6_days_reg) + 18'(EPOCH_WEEKDAY);
        s7_wprod_next = 34'(s7_dayp4_next) * 34'(R_7);
    end

    // weekday remainder, day-of-year product
    always_comb
    begin
        s8_wq    = s7_wprod_reg[33:18];
        s8_wdiff = s7_dayp4_reg - 18'(s8_wq) * 18'(DAYS_PER_WEEK);
        s8_wrem  = s8_wdiff[3:0];
        if (s8_wrem >= 4'(DAYS_PER_WEEK))
        begin
            s8_wday_next = 3'(s8_wrem - 4'(DAYS_PER_WEEK));
        end
        else
        begin
            s8_wday_next = s8_wrem[2:0];
        end
        s8_yprod_next = 31'(s7_yrem_reg) * 31'(R_24);
    end

    // zero-based day of year
    always_comb
    begin
        s9_q    = s8_yprod_reg[29:21];
        s9_diff = s8_yrem_reg - 14'(s9_q) * 14'(HOURS_PER_DAY);
        s9_rem  = s9_diff[5:0];
        if (s9_rem >= 6'(HOURS_PER_DAY))
        begin
            s9_doy0_next = s9_q + 9'd1;
        end
        else
        begin
            s9_doy0_next = s9_q;
        end
    end

    // month lookup with the leap day as its own case
    always_comb
    begin
        s10_doy  = s9_doy0_reg + 9'd1;
        s10_leap = (s9_year_reg[1:0] == 2'd0);
        if (s10_leap && (s10_doy > 9'(LEAP_DAY_DOY)))
        begin
            s10_d = s10_doy - 9'd1;
        end
        else
        begin
            s10_d = s10_doy;
        end
        for (int i = 0; i < 11; i++)
        begin
            s10_past[i] = (s10_d > MONTH_START[i+1]);
        end
        if (s10_leap && (s10_doy == 9'(LEAP_DAY_DOY)))
        begin
            s10_mon_next  = 4'd1;
            s10_mday_next = 5'd29;
        end
        else
        begin
            s10_mon_next  = 4'($countones(s10_past));
            s10_mday_next = 5'(s10_d - MONTH_START[s10_mon_next]);
        end
    end

    // pipeline registers, each stage loads on its own enable
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s0_raw_reg <= s0_raw_next;
        end
        if (ctrl.load[1])
        begin
            s1_prod_reg <= s1_prod_next;
            s1_raw_reg  <= s0_raw_reg;
        end
        if (ctrl.load[2])
        begin
            s2_mins_reg <= s2_mins_next;
            s2_sec_reg  <= s2_sec_next;
        end
        if (ctrl.load[3])
        begin
            s3_prod_reg <= s3_prod_next;
            s3_mins_reg <= s2_mins_reg;
            s3_sec_reg  <= s2_sec_reg;
        end
        if (ctrl.load[4])
        begin
            s4_hours_reg <= s4_hours_next;
            s4_min_reg   <= s4_min_next;
            s4_sec_reg   <= s3_sec_reg;
        end
        if (ctrl.load[5])
        begin
            s5_dprod_reg <= s5_dprod_next;
            s5_cprod_reg <= s5_cprod_next;
            s5_hours_reg <= s4_hours_reg;
            s5_min_reg   <= s4_min_reg;
            s5_sec_reg   <= s4_sec_reg;
        end
        if (ctrl.load[6])
        begin
            s6_days_reg <= s6_days_next;
            s6_cyc_reg  <= s6_cyc_next;
            s6_crem_reg <= s6_crem_next;
            s6_hour_reg <= s6_hour_next;
            s6_min_reg  <= s5_min_reg;
            s6_sec_reg  <= s5_sec_reg;
        end
        if (ctrl.load[7])
        begin
            s7_dayp4_reg <= s7_dayp4_next;
            s7_wprod_reg <= s7_wprod_next;
            s7_year_reg  <= s7_year_next;
            s7_yrem_reg  <= s7_yrem_next;
            s7_hour_reg  <= s6_hour_reg;
            s7_min_reg   <= s6_min_reg;
            s7_sec_reg   <= s6_sec_reg;
        end
        if (ctrl.load[8])
        begin
            s8_wday_reg  <= s8_wday_next;
            s8_yprod_reg <= s8_yprod_next;
            s8_yrem_reg  <= s7_yrem_reg;
            s8_year_reg  <= s7_year_reg;
            s8_hour_reg  <= s7_hour_reg;
            s8_min_reg   <= s7_min_reg;
            s8_sec_reg   <= s7_sec_reg;
        end
        if (ctrl.load[9])
        begin
            s9_doy0_reg <= s9_doy0_next;
            s9_wday_reg <= s8_wday_reg;
            s9_year_reg <= s8_year_reg;
            s9_hour_reg <= s8_hour_reg;
            s9_min_reg  <= s8_min_reg;
            s9_sec_reg  <= s8_sec_reg;
        end
        if (ctrl.load[10])
        begin
            s10_mday_reg <= s10_mday_next;
            s10_mon_reg  <= s10_mon_next;
            s10_wday_reg <= s9_wday_reg;
            s10_year_reg <= s9_year_reg;
            s10_hour_reg <= s9_hour_reg;
            s10_min_reg  <= s9_min_reg;
            s10_sec_reg  <= s9_sec_reg;
        end
    end

    // result beat
    assign second           = s10_sec_reg;
    assign minute           = s10_min_reg;
    assign hour             = s10_hour_reg;
    assign day_of_month     = s10_mday_reg;
    assign month            = s10_mon_reg;
    assign years_since_1900 = s10_year_reg;
    assign weekday          = s10_wday_reg;

    // range flags on the result fields
    assign time_ok = (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24);
    assign date_ok = (month < 4'd12) && (day_of_month != 5'd0) && (weekday < 3'd7);
    assign year_ok = (years_since_1900 >= 8'd70) && (years_since_1900 <= 8'd138);

    // checks on the result fields and on backpressure
    `ES2C_ASSERT_IMPL(a_time_range, out_valid, time_ok, "time field out of range")
    `ES2C_ASSERT_IMPL(a_date_range, out_valid, date_ok, "date field out of range")
    `ES2C_ASSERT_IMPL(a_year_range, out_valid, year_ok, "year out of range")
    `ES2C_ASSERT_IMPL(a_stall_full, in_stall, out_valid && out_stall, "early input stall")

endmodule

// ===== rtl/core/es2c_pipe_ctrl.sv =====
// valid tracking and per-stage load enables for the conversion pipeline
`timescale 1ns / 1ps

module es2c_pipe_ctrl
    import es2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_stall,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] upper;
    logic [NUM_STAGES-1:0] fill;

    // a stage loads unless it and every stage after it hold a beat and the output is stalled
    always_comb
    begin
        load  = '0;
        upper = '0;
        fill  = '0;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            upper   = valid_reg >> i;
            fill    = ~({NUM_STAGES{1'b1}} >> i);
            load[i] = !out_stall || ((upper | fill) != {NUM_STAGES{1'b1}});
        end
    end

    // valid bits follow the data
    always_comb
    begin
        valid_next    = valid_reg;
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

endmodule
